// ===== design/leg_gait_trajectory_defines.svh =====
// Assertion macros for the verification files of the gait block.
`ifndef LEG_GAIT_TRAJECTORY_DEFINES_SVH
`define LEG_GAIT_TRAJECTORY_DEFINES_SVH

// Same-cycle implication, sampled on the block clock and held off in reset.
`define LGT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("leg_gait_trajectory: check failed");

// Implication whose consequent is checked later, after a delay given by n.
`define LGT_ASSERT_DELAY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("leg_gait_trajectory: check failed");

`endif

// ===== design/lgt_pkg.sv =====
package lgt_pkg;

  localparam int PHASE_BITS = 16;
  localparam int CP         = 12;
  localparam int FB         = PHASE_BITS - 2;
  localparam int FRAC       = 16;
  localparam int CP_BIAS    = 2048;
  localparam int PTW        = 12;
  localparam int WW         = PTW + FRAC;
  localparam int REF_W      = 14;
  localparam int POS_W      = 15;
  localparam int POS_LIMIT  = 16000;
  // Input register, one stage per curve level, output register.
  localparam int LATENCY    = CP + 1;
  // Stage at which the stance dip is finished.
  localparam int STG_DIP    = 7;
  localparam int K_SH       = 29 - FB;

  localparam logic [PHASE_BITS:0] D_PHASE = (PHASE_BITS + 1)'(3) << FB;

  // ceil(2^32 / 3): exact floor division by three for values below 2^31.
  localparam logic [30:0] RCP3    = 31'd1431655766;
  localparam logic [33:0] SIN_A1  = 34'd5298703516;
  localparam logic [33:0] SIN_A2  = 34'd4358008962;
  localparam logic [30:0] SIN_A3  = 31'd1433727482;
  localparam logic [27:0] SIN_A4  = 28'd252684340;
  localparam logic [30:0] Q30_ONE = 31'd1073741824;

  typedef enum logic [1:0] {
    CFG_X_REF = 2'd0,
    CFG_Y_REF = 2'd1
  } cfg_idx_e;

  typedef logic [WW-1:0] cp_arr_t [CP];

  localparam int CP_X [CP] = '{-1200, -1680, -1800, -1800, -1800, 0, 0, 0,
                               1800, 1800, 1680, 1200};
  localparam int CP_Y [CP] = '{0, 0, 720, 720, 720, 720, 720, 1088,
                               1088, 1088, 0, 0};

  function automatic cp_arr_t cp_scale(input int pts [CP]);
    cp_arr_t r;
    for (int i = 0; i < CP; i++) begin
      r[i] = WW'(pts[i] + CP_BIAS) << FRAC;
    end
    return r;
  endfunction

  // One rounded interpolation step: (a*(M-q) + b*q + M/2) / M with M = 2^FB,
  // written as a*M + (b-a)*q so that a single multiplier does the work.
  function automatic logic [WW-1:0] lerp(input logic [WW-1:0] a,
                                         input logic [WW-1:0] b,
                                         input logic [FB-1:0] q);
    logic signed [WW:0]        diff;
    logic signed [WW+FB+2:0]   acc;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    acc  = $signed({3'b000, a, {FB{1'b0}}})
         + diff * $signed({1'b0, q})
         + $signed({{(WW+3){1'b0}}, 1'b1, {(FB-1){1'b0}}});
    return acc[WW+FB-1:FB];
  endfunction

endpackage

// ===== design/leg_gait_trajectory.sv =====
// Foot trajectory for one leg: each started phase gives one (foot_x, foot_y,
// in_swing) result, marked by done_o for exactly one cycle when the output
// register holds it. A new phase can start in every cycle; busy is
// always low and the receiver cannot stall the result, which is shown once.
// The latency is set by the swing curve: eleven de Casteljau levels, one
// register stage each, between an input and an output register. Reference
// offsets are taken at the output stage and apply to the swing curve only.
module leg_gait_trajectory import lgt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [15:0]             phase_i,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [REF_W-1:0]        cfg_wdata_i,
  output logic                    done_o,
  output logic signed [POS_W-1:0] foot_x_o,
  output logic signed [POS_W-1:0] foot_y_o,
  output logic                    in_swing_o
);

  localparam int NLVL   = CP - 1;
  localparam int NDIP   = NLVL - STG_DIP + 1;
  localparam cp_arr_t CPX_W = cp_scale(CP_X);
  localparam cp_arr_t CPY_W = cp_scale(CP_Y);

  logic signed [REF_W-1:0] xref_q, yref_q;
  logic [LATENCY-1:0]      vld_q;
  logic [PHASE_BITS-1:0]   p_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xref_q <= '0;
      yref_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_X_REF: xref_q <= cfg_wdata_i;
        CFG_Y_REF: yref_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      p_q <= phase_i[PHASE_BITS-1:0];
    end
  end

  // Stage 0 decode.
  logic                  swing0;
  logic [FB-1:0]         q0;
  logic [PHASE_BITS:0]   p_ext, diff0;
  logic [PHASE_BITS:0]   two_p, wn0;
  logic [PHASE_BITS+9:0] fx_prod;
  logic [PHASE_BITS+9:0] fx_rnd;

  always_comb begin
    p_ext  = {1'b0, p_q};
    swing0 = p_ext > D_PHASE;
    diff0  = p_ext - D_PHASE;
    q0     = diff0[FB-1:0];
    two_p  = {p_q, 1'b0};
    wn0    = (two_p >= D_PHASE) ? two_p - D_PHASE : D_PHASE - two_p;
    fx_prod = (PHASE_BITS + 10)'(p_q) * (PHASE_BITS + 10)'(800);
    fx_rnd  = fx_prod + ((PHASE_BITS + 10)'(1) << (FB - 1));
  end

  // Swing curve lanes.
  logic [WW-1:0] wx, wy;

  lgt_bezier_lane u_lane_x (
    .clk_i (clk_i),
    .cp_i  (CPX_W),
    .q_i   (q0),
    .w_o   (wx)
  );

  lgt_bezier_lane u_lane_y (
    .clk_i (clk_i),
    .cp_i  (CPY_W),
    .q_i   (q0),
    .w_o   (wy)
  );

  // Stance pipeline: stages 1 to 7 build the cosine dip.
  logic [30:0]  xw0;
  logic [61:0]  prod1_q;
  logic [59:0]  prod2_q;
  logic [56:0]  prod3_q;
  logic [59:0]  prod4_q;
  logic [62:0]  prod5_q;
  logic [62:0]  prod6_q;
  logic [28:0]  z3_q, z4_q, z5_q;
  logic [29:0]  wq2;
  logic [28:0]  z2;
  logic [30:0]  h3;
  logic [33:0]  h2, h1;
  logic [32:0]  t7;
  logic [30:0]  c7;
  logic [38:0]  y_rnd;
  logic signed [8:0] fy7;
  logic signed [12:0] fx1;
  logic signed [12:0] fx_sh_q [NLVL];
  logic               sw_sh_q [NLVL];
  logic signed [8:0]  fy_sh_q [NDIP];

  always_comb begin
    xw0 = 31'({wn0, {K_SH{1'b0}}});
    fx1 = 13'sd1200 - $signed({1'b0, fx_rnd[FB+11:FB]});
    wq2 = prod1_q[61:32];
    z2  = prod2_q[58:30];
    h3  = SIN_A3 - 31'(prod3_q[56:30]);
    h2  = SIN_A2 - 34'(prod4_q[59:30]);
    h1  = SIN_A1 - 34'(prod5_q[62:30]);
    t7  = prod6_q[62:30];
    c7  = (t7 >= 33'(Q30_ONE)) ? '0 : 31'(33'(Q30_ONE) - t7);
    y_rnd = 39'(c7) * 39'(160) + (39'(1) << 29);
    fy7 = -$signed({1'b0, y_rnd[37:30]});
  end

  always_ff @(posedge clk_i) begin
    prod1_q <= 62'(xw0) * 62'(RCP3);
    prod2_q <= 60'(wq2) * 60'(wq2);
    z3_q    <= z2;
    prod3_q <= 57'(z2) * 57'(SIN_A4);
    z4_q    <= z3_q;
    prod4_q <= 60'(z3_q) * 60'(h3);
    z5_q    <= z4_q;
    prod5_q <= 63'(z4_q) * 63'(h2);
    prod6_q <= 63'(z5_q) * 63'(h1);
    fx_sh_q[0] <= fx1;
    sw_sh_q[0] <= swing0;
    fy_sh_q[0] <= fy7;
    for (int i = 1; i < NLVL; i++) begin
      fx_sh_q[i] <= fx_sh_q[i-1];
      sw_sh_q[i] <= sw_sh_q[i-1];
    end
    for (int i = 1; i < NDIP; i++) begin
      fy_sh_q[i] <= fy_sh_q[i-1];
    end
  end

  // Output stage: round the curve, add the offsets, pick the path, saturate.
  logic [WW-1:0]      rx, ry;
  logic signed [15:0] sx, sy, fx_sel, fy_sel;
  logic signed [POS_W-1:0] fx_d, fy_d;

  function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [15:0] v);
    if (v > 16'sd16000) begin
      return POS_W'(POS_LIMIT);
    end else if (v < -16'sd16000) begin
      return -POS_W'(POS_LIMIT);
    end
    return v[POS_W-1:0];
  endfunction

  always_comb begin
    rx = wx + (WW'(1) << (FRAC - 1));
    ry = wy + (WW'(1) << (FRAC - 1));
    sx = $signed({4'b0, rx[WW-1:FRAC]}) - 16'sd2048 + 16'(xref_q);
    sy = $signed({4'b0, ry[WW-1:FRAC]}) - 16'sd2048 + 16'(yref_q);
    fx_sel = sw_sh_q[NLVL-1] ? sx : 16'(fx_sh_q[NLVL-1]);
    fy_sel = sw_sh_q[NLVL-1] ? sy : 16'(fy_sh_q[NDIP-1]);
    fx_d = clamp_pos(fx_sel);
    fy_d = clamp_pos(fy_sel);
  end

  always_ff @(posedge clk_i) begin
    foot_x_o   <= fx_d;
    foot_y_o   <= fy_d;
    in_swing_o <= sw_sh_q[NLVL-1];
  end

  assign done_o = vld_q[LATENCY-1];

endmodule

// ===== design/lgt_bezier_lane.sv =====
module lgt_bezier_lane import lgt_pkg::*; (
  input  logic          clk_i,
  input  cp_arr_t       cp_i,
  input  logic [FB-1:0] q_i,
  output logic [WW-1:0] w_o
);

  // One register stage per de Casteljau level; the top entry of each level
  // is carried along unchanged and is pruned by synthesis.
  logic [WW-1:0] w_q [CP-1][CP];
  logic [FB-1:0] q_q [CP-1];

  for (genvar j = 0; j < CP - 1; j++) begin : g_lvl
    logic [WW-1:0] src [CP];
    logic [WW-1:0] w_d [CP];
    logic [FB-1:0] qs;

    if (j == 0) begin : g_first
      assign src = cp_i;
      assign qs  = q_i;
    end else begin : g_next
      assign src = w_q[j-1];
      assign qs  = q_q[j-1];
    end

    always_comb begin
      for (int i = 0; i < CP; i++) begin
        if (i < CP - 1) begin
          w_d[i] = lerp(src[i], src[(i < CP - 1) ? i + 1 : i], qs);
        end else begin
          w_d[i] = src[i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      w_q[j] <= w_d;
      q_q[j] <= qs;
    end
  end

  assign w_o = w_q[CP-2][0];

endmodule

// ===== design/lgt_checker.sv =====
`include "leg_gait_trajectory_defines.svh"

module lgt_checker import lgt_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic [15:0]             phase_i,
  input logic                    cfg_we_i,
  input logic [1:0]              cfg_idx_i,
  input logic [REF_W-1:0]        cfg_wdata_i,
  input logic                    done_o,
  input logic signed [POS_W-1:0] foot_x_o,
  input logic signed [POS_W-1:0] foot_y_o,
  input logic                    in_swing_o
);

  // Every transaction gives a result after the fixed latency, and no other.
  `LGT_ASSERT_DELAY(a_latency, start && !busy, LATENCY, done_o)
  `LGT_ASSERT_IMPL(a_no_spurious, done_o, $past(start && !busy, LATENCY))
  // Stance results stay on the straight line and never rise above ground.
  `LGT_ASSERT_IMPL(a_stance_x, done_o && !in_swing_o, foot_x_o <= 15'sd1200 && foot_x_o >= -15'sd1200)
  `LGT_ASSERT_IMPL(a_stance_y, done_o && !in_swing_o, foot_y_o <= 15'sd0 && foot_y_o >= -15'sd160)

endmodule

bind leg_gait_trajectory lgt_checker u_lgt_checker (.*);

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lgt_pkg::*;

  // Indexes that decode to no register; writes to them must be ignored.
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = LATENCY + 8;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    swing;
  } foot_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [15:0]             phase_i = '0;
  logic                    cfg_we_i = 1'b0;
  logic [1:0]              cfg_idx_i = CFG_X_REF;
  logic [REF_W-1:0]        cfg_wdata_i = '0;
  logic                    done_o;
  logic signed [POS_W-1:0] foot_x_o;
  logic signed [POS_W-1:0] foot_y_o;
  logic                    in_swing_o;

  logic             busy_s = 1'b0;
  logic [REF_W-1:0] x_ref_m = '0;
  logic [REF_W-1:0] y_ref_m = '0;
  foot_t            pending_feet [$];
  int               errors = 0;
  int               n_sent = 0;
  int               n_checked = 0;
  int               n_swing = 0;
  int               quiet_cycles = 0;
  bit               allow_idle = 1'b1;

  leg_gait_trajectory u_top (
    .clk_i, .rst_ni, .start, .busy, .phase_i, .cfg_we_i, .cfg_idx_i,
    .cfg_wdata_i, .done_o, .foot_x_o, .foot_y_o, .in_swing_o
  );

  always #10 clk_i = ~clk_i;

  function automatic longint curve_point(input int pts [CP], input longint unsigned q);
    longint unsigned w [CP];
    longint unsigned m;
    longint unsigned r;
    m = 64'd1 << FB;
    r = m - q;
    for (int i = 0; i < CP; i++) w[i] = longint'(pts[i] + CP_BIAS) << FRAC;
    for (int lvl = CP - 1; lvl > 0; lvl--)
      for (int i = 0; i < lvl; i++) w[i] = (w[i] * r + w[i+1] * q + (m >> 1)) >> FB;
    return longint'((w[0] + (64'd1 << (FRAC - 1))) >> FRAC) - CP_BIAS;
  endfunction

  // Polynomial cosine around mid-stance gives the foot dip.
  function automatic longint stance_depth(input longint unsigned p, input longint unsigned d);
    longint unsigned wn, wq, z, h, t, c;
    wn = (2 * p >= d) ? 2 * p - d : d - 2 * p;
    wq = (wn << 29) / d;
    z  = (wq * wq) >> 30;
    h  = 64'(SIN_A3) - ((z * 64'(SIN_A4)) >> 30);
    h  = 64'(SIN_A2) - ((z * h) >> 30);
    h  = 64'(SIN_A1) - ((z * h) >> 30);
    t  = (z * h) >> 30;
    c  = (t >= 64'(Q30_ONE)) ? 64'd0 : 64'(Q30_ONE) - t;
    return -longint'((160 * c + (64'(Q30_ONE) >> 1)) >> 30);
  endfunction

  function automatic longint clamp_pos(input longint v);
    if (v > POS_LIMIT) return POS_LIMIT;
    if (v < -POS_LIMIT) return -POS_LIMIT;
    return v;
  endfunction

  function automatic foot_t foot_target(input logic [15:0] ph);
    foot_t f;
    longint unsigned p, d;
    longint fx, fy;
    p = ph;
    d = 64'(D_PHASE);
    if (p <= d) begin
      f.swing = 1'b0;
      fx = 1200 - longint'((2400 * p + (d >> 1)) / d);
      fy = stance_depth(p, d);
    end else begin
      f.swing = 1'b1;
      fx = curve_point(CP_X, p - d) + longint'($signed(x_ref_m));
      fy = curve_point(CP_Y, p - d) + longint'($signed(y_ref_m));
    end
    f.x = POS_W'(clamp_pos(fx));
    f.y = POS_W'(clamp_pos(fy));
    return f;
  endfunction

  always @(negedge clk_i) busy_s <= busy;

  // Record the expectation at each start transaction, check each strobed result.
  always @(posedge clk_i) begin
    foot_t exp_f;
    foot_t got_f;
    if (rst_ni) begin
      if (start && !busy) begin
        pending_feet.push_back(foot_target(phase_i));
        n_sent++;
      end
      if (done_o) begin
        got_f = '{foot_x_o, foot_y_o, in_swing_o};
        n_checked++;
        if (in_swing_o) n_swing++;
        if (pending_feet.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result x=%0d y=%0d swing=%0b",
                                     foot_x_o, foot_y_o, in_swing_o);
        end else begin
          exp_f = pending_feet.pop_front();
          if (got_f !== exp_f) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected x=%0d y=%0d swing=%0b, got x=%0d y=%0d swing=%0b",
                       exp_f.x, exp_f.y, exp_f.swing, foot_x_o, foot_y_o, in_swing_o);
          end
        end
      end
      if ((start && !busy) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_phase(input logic [15:0] ph);
    start   <= 1'b1;
    phase_i <= ph;
    do @(posedge clk_i); while (busy_s);
    if (allow_idle && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_feet.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [REF_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_X_REF) x_ref_m = data;
    else if (idx == CFG_Y_REF) y_ref_m = data;
    @(posedge clk_i);
  endtask

  task automatic set_refs(input logic [REF_W-1:0] xr, input logic [REF_W-1:0] yr);
    drain();
    write_reg(CFG_X_REF, xr);
    write_reg(CFG_Y_REF, yr);
  endtask

  function automatic logic [15:0] rand_phase();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 49152));
      1:       return 16'($urandom_range(49153, 65535));
      2:       return 16'($urandom_range(49140, 49170));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed;
    logic [15:0] corners [$] = '{16'd0, 16'd1, 16'd16383, 16'd16384, 16'd24576,
                                 16'd32768, 16'd49151, 16'd49152, 16'd49153,
                                 16'd49154, 16'd57344, 16'd65534, 16'd65535,
                                 16'hAAAA, 16'h5555};
    allow_idle = 1'b0;
    foreach (corners[i]) send_phase(corners[i]);
    set_refs(14'sd8000, -14'sd8000);
    for (int i = 11; i < corners.size(); i++) send_phase(corners[i]);
    // Raw patterns outside the nominal range must sign-extend.
    set_refs(14'h1FFF, 14'h2000);
    send_phase(16'd49153);
    send_phase(16'd65535);
    allow_idle = 1'b1;
  endtask

  task automatic test_spare_index;
    drain();
    write_reg(CFG_SPARE_A, 14'h2AAA);
    write_reg(CFG_SPARE_B, 14'h1555);
    repeat (8) send_phase(16'($urandom_range(49153, 65535)));
  endtask

  task automatic test_random_refs(input int n_items);
    set_refs(14'($urandom), 14'($urandom));
    repeat (n_items) send_phase(rand_phase());
  endtask

  task automatic test_pause_for_results;
    repeat (40) send_phase(rand_phase());
    drain();
    repeat (40) send_phase(rand_phase());
  endtask

  task automatic test_back_to_back;
    set_refs(-14'sd8000, 14'sd8000);
    allow_idle = 1'b0;
    repeat (360) send_phase(rand_phase());
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_spare_index();
    for (int k = 0; k < 10; k++) test_random_refs(100);
    test_pause_for_results();
    set_refs(14'sd0, 14'sd0);
    test_random_refs(80);
    test_back_to_back();
    drain();
    $display("covered %0d phases, %0d results checked (%0d in swing)",
             n_sent, n_checked, n_swing);
    $display("reference offsets swept over zero, both extremes and random patterns");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
